@@ src/bba_pkg.sv @@
package bba_pkg;

    // Bitmap geometry: one bit per block, 64 blocks per word.
    localparam int NUM_WORDS  = 512;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;
    localparam int BLK_W      = 15;
    // Block numbers carry 15 bits, so at most 512 words are ever scanned.
    localparam int ADDR_WORDS = 512;
    localparam int SCAN_WORDS = (NUM_WORDS < ADDR_WORDS) ? NUM_WORDS : ADDR_WORDS;
    localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FILL_W     = $clog2(NUM_WORDS + 1);
    localparam int BWORD_W    = BLK_W - BIT_W;

    localparam logic [WORD_BITS-1:0] ALL_USED = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FCHK,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic start;
        logic advance;
        logic finish;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic word_full;
        logic last_word;
    } t_dp_stat;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        t_status          st;
    } t_result;

endpackage

@@ src/bba_ctrl.sv @@
module bba_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_cmd,
    input  logic                 i_out_free,
    input  bba_pkg::t_dp_stat    i_stat,
    output logic                 o_in_stall,
    output bba_pkg::t_ctrl_cmd   o_cmd
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = (i_cmd == bba_pkg::CMD_FREE) ? bba_pkg::S_FCHK
                                                           : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN: begin
                // stop at the first word with a clear bit or at the last word
                if (!i_stat.word_full || i_stat.last_word) begin
                    o_cmd.finish = 1'b1;
                    n_state = bba_pkg::S_PUSH;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            bba_pkg::S_FCHK: begin
                o_cmd.finish = 1'b1;
                n_state = bba_pkg::S_PUSH;
            end
            bba_pkg::S_PUSH: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ src/bba_dp.sv @@
module bba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd,
    input  logic [bba_pkg::BLK_W-1:0]     i_free_block,
    input  bba_pkg::t_ctrl_cmd            i_ctrl,
    output bba_pkg::t_dp_stat             o_stat,
    output bba_pkg::t_result              o_result
);

    localparam int AW = bba_pkg::WORD_AW;
    localparam int FW = bba_pkg::FILL_W;
    localparam int WB = bba_pkg::WORD_BITS;
    localparam int BW = bba_pkg::BIT_W;
    localparam int KW = bba_pkg::BWORD_W;

    // Lowest set bit of a 64-bit word, as a six-level halving search.
    function automatic logic [BW-1:0] lowest_one(input logic [WB-1:0] x);
        logic [WB-1:0] v;
        logic [BW-1:0] idx;
        v   = x;
        idx = '0;
        if (v[31:0] == 32'd0) begin idx[5] = 1'b1; v = v >> 32; end
        if (v[15:0] == 16'd0) begin idx[4] = 1'b1; v = v >> 16; end
        if (v[7:0]  == 8'd0)  begin idx[3] = 1'b1; v = v >> 8;  end
        if (v[3:0]  == 4'd0)  begin idx[2] = 1'b1; v = v >> 4;  end
        if (v[1:0]  == 2'd0)  begin idx[1] = 1'b1; v = v >> 2;  end
        if (v[0]    == 1'b0)  begin idx[0] = 1'b1;              end
        return idx;
    endfunction

    logic [WB-1:0]             mem [bba_pkg::NUM_WORDS];
    logic [WB-1:0]             r_q;
    logic                      r_q_fresh;
    logic [FW-1:0]             r_fill;
    logic [AW-1:0]             r_addr;
    logic                      r_op;
    logic [bba_pkg::BLK_W-1:0] r_blk;
    logic                      r_oor;
    bba_pkg::t_result          r_res;

    logic [AW-1:0]             rd_addr;
    logic [bba_pkg::BWORD_W-1:0] free_word;
    logic [WB-1:0]             word;
    logic [BW-1:0]             zero_idx;
    logic [WB-1:0]             alloc_mask;
    logic [WB-1:0]             free_mask;
    logic                      wr_en;
    logic [WB-1:0]             wr_data;
    bba_pkg::t_result          n_res;

    assign free_word = i_free_block[bba_pkg::BLK_W-1:BW];

    always_comb begin
        if (i_ctrl.start) begin
            rd_addr = (i_cmd == bba_pkg::CMD_FREE) ? AW'(free_word) : '0;
        end else begin
            rd_addr = r_addr + AW'(1);
        end
    end

    // Words at or above the fill mark were never written and read as free.
    assign word       = r_q_fresh ? '0 : r_q;
    assign zero_idx   = lowest_one(~word);
    assign alloc_mask = WB'(1) << zero_idx;
    assign free_mask  = WB'(1) << r_blk[BW-1:0];

    assign o_stat.word_full = (word == bba_pkg::ALL_USED);
    assign o_stat.last_word = (r_addr == AW'(bba_pkg::SCAN_WORDS - 1));

    always_comb begin
        wr_en   = 1'b0;
        wr_data = word | alloc_mask;
        n_res   = r_res;
        if (i_ctrl.finish) begin
            if (r_op == bba_pkg::CMD_ALLOC) begin
                if (word != bba_pkg::ALL_USED) begin
                    wr_en     = 1'b1;
                    n_res.blk = {KW'(r_addr), zero_idx};
                    n_res.st  = bba_pkg::ST_OK;
                end else begin
                    n_res.blk = '0;
                    n_res.st  = bba_pkg::ST_FULL;
                end
            end else begin
                n_res.blk = r_blk;
                if (!r_oor && (word & free_mask) != '0) begin
                    wr_en    = 1'b1;
                    wr_data  = word & ~free_mask;
                    n_res.st = bba_pkg::ST_OK;
                end else begin
                    n_res.st = bba_pkg::ST_NOT_ALLOC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        r_q       <= mem[rd_addr];
        r_q_fresh <= (FW'(rd_addr) >= r_fill);
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_op   <= i_cmd;
            r_blk  <= i_free_block;
            r_oor  <= (32'(free_word) >= bba_pkg::NUM_WORDS);
            r_addr <= rd_addr;
        end else if (i_ctrl.advance) begin
            r_addr <= rd_addr;
        end
    end

    // Written words always form a prefix, so a write at the mark grows it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (wr_en && FW'(r_addr) == r_fill) begin
            r_fill <= r_fill + FW'(1);
        end
    end

    assign o_result = r_res;

endmodule

@@ src/bitmap_block_allocator_core.sv @@
// Channel  Direction  Handshake                 Beat payload
// in       input      i_in_valid / o_in_stall   i_cmd, i_free_block
// out      output     o_out_valid / i_out_stall o_block_number, o_status
//
// Allocate: scan k words, k being 1 to 512, then hand off; a new beat is taken
// only after the hand-off. The scan reads one bitmap word per cycle from the
// single read port of the word store. Free: read, check and write, hand-off.
// At reset a fill mark stands for the cleared store, no sweep.
// The output register holds a result while out is stalled; the next beat is
// taken meanwhile and its result waits in the datapath until the register frees.
module bitmap_block_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [bba_pkg::BLK_W-1:0]     i_free_block,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bba_pkg::BLK_W-1:0]     o_block_number,
    output logic [1:0]                    o_status
);

    bba_pkg::t_ctrl_cmd ctrl_cmd;
    bba_pkg::t_dp_stat  dp_stat;
    bba_pkg::t_result   dp_result;
    logic               out_free;

    logic               r_out_valid;
    bba_pkg::t_result   r_out;

    // The output register can take a beat when empty or draining this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (ctrl_cmd)
    );

    bba_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_free_block (i_free_block),
        .i_ctrl       (ctrl_cmd),
        .o_stat       (dp_stat),
        .o_result     (dp_result)
    );

    // Load a finished result, drop the valid once taken, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_cmd.load_out) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_block_number = r_out.blk;
    assign o_status       = r_out.st;

endmodule

@@ verif/bitmap_block_allocator_core_tb.sv @@
module bitmap_block_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Pacing modes: which side of the block idles, and how often.
    localparam logic [1:0] PACE_NONE   = 2'd0;
    localparam logic [1:0] PACE_SENDER = 2'd1;
    localparam logic [1:0] PACE_RECVR  = 2'd2;
    localparam logic [1:0] PACE_BOTH   = 2'd3;

    localparam int BLK_W     = bba_pkg::BLK_W;
    localparam int BIT_W     = bba_pkg::BIT_W;
    localparam int WORD_BITS = bba_pkg::WORD_BITS;
    localparam int NUM_WORDS = bba_pkg::NUM_WORDS;

    localparam int RANDOM_BEATS = 1146;
    localparam int PHASE_BEATS  = 287;
    // A full 512-word scan plus hand-off bounds each beat; the drain after the
    // last result waits out one such scan.
    localparam int DRAIN_CYCLES = 600;
    // Slowest correct run: every beat a full scan plus hand-off, plus heavy idling,
    // taken several times over.
    localparam int LIMIT_CYCLES = 3_000_000;
    // Long output hold-off that backs the block up into its input.
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        bba_pkg::t_cmd    cmd;
        logic [BLK_W-1:0] blk;
        logic [1:0]       pace;
    } t_req_beat;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic             i_cmd        = 1'b0;
    logic [BLK_W-1:0] i_free_block = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic [BLK_W-1:0] o_block_number;
    logic [1:0]       o_status;

    bitmap_block_allocator_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_free_block   (i_free_block),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_block_number (o_block_number),
        .o_status       (o_status)
    );

    // Requests not yet taken by the block, and results owed by it.
    t_req_beat        pending_reqs[$];
    bba_pkg::t_result owed_results[$];

    // Shadow copy of the usage bitmap, cleared like the block at reset.
    logic [WORD_BITS-1:0] used_map [NUM_WORDS];

    int  beats_in     = 0;
    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  grants       = 0;
    int  releases     = 0;
    int  rejects      = 0;
    int  full_reports = 0;
    int  deepest_word = 0;
    logic [1:0] rx_pace = PACE_NONE;
    int  hold_left    = 0;
    logic hold_done   = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Allocate: take the lowest clear bit of the first word that is not full,
    // scanning no further than block numbers can reach. Free: clear the named
    // bit, or reject if it is already clear or lies past the bitmap.
    function automatic bba_pkg::t_result grant_or_release(bba_pkg::t_cmd cmd,
                                                          logic [BLK_W-1:0] blk);
        bba_pkg::t_result r;
        logic             found;
        int               w;
        r.blk = '0;
        r.st  = bba_pkg::ST_FULL;
        found = 1'b0;
        if (cmd == bba_pkg::CMD_ALLOC) begin
            for (int wi = 0; wi < bba_pkg::SCAN_WORDS && !found; wi++) begin
                if (used_map[wi] != bba_pkg::ALL_USED) begin
                    for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (!used_map[wi][b]) begin
                            used_map[wi][b] = 1'b1;
                            r.blk = BLK_W'(wi * WORD_BITS + b);
                            r.st  = bba_pkg::ST_OK;
                            found = 1'b1;
                            if (wi > deepest_word) deepest_word = wi;
                        end
                    end
                end
            end
            if (found) grants++;
            else full_reports++;
        end else begin
            w     = int'(blk >> BIT_W);
            r.blk = blk;
            if (w >= NUM_WORDS || !used_map[w][blk[BIT_W-1:0]]) begin
                r.st = bba_pkg::ST_NOT_ALLOC;
                rejects++;
            end else begin
                used_map[w][blk[BIT_W-1:0]] = 1'b0;
                r.st = bba_pkg::ST_OK;
                releases++;
            end
        end
        return r;
    endfunction

    function automatic int send_gap_pct(logic [1:0] pace);
        return (pace == PACE_SENDER) ? 49 : (pace == PACE_BOTH) ? 28 : 0;
    endfunction

    function automatic int recv_stall_pct(logic [1:0] pace);
        return (pace == PACE_RECVR) ? 49 : (pace == PACE_BOTH) ? 28 : 0;
    endfunction

    task automatic queue_request(bba_pkg::t_cmd cmd, logic [BLK_W-1:0] blk,
                                 logic [1:0] pace);
        t_req_beat q;
        q.cmd  = cmd;
        q.blk  = blk;
        q.pace = pace;
        pending_reqs.push_back(q);
    endtask

    task automatic flag_mismatch(string what, int exp_blk, int exp_st);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected block %0d status %0d, got block %0d status %0d",
                     $realtime, what, exp_blk, exp_st, o_block_number, o_status);
    endtask

    // Driver: on an accepted beat, predict its result and advance the queue.
    // Hold the payload while stalled; pick a new beat only when the line is
    // free, idling at random according to the beat's pacing mode.
    always @(posedge i_clk) begin : drive_requests
        logic      took;
        t_req_beat spent;
        took = 1'b0;
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_cmd        <= bba_pkg::CMD_ALLOC;
            i_free_block <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                owed_results.push_back(grant_or_release(bba_pkg::t_cmd'(i_cmd),
                                                        i_free_block));
                spent    = pending_reqs.pop_front();
                rx_pace  <= spent.pace;
                beats_in <= beats_in + 1;
                took     = 1'b1;
            end
            if (!i_in_valid || took) begin
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99) >= send_gap_pct(pending_reqs[0].pace)) begin
                    i_in_valid   <= 1'b1;
                    i_cmd        <= pending_reqs[0].cmd;
                    i_free_block <= pending_reqs[0].blk;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing: one long hold-off early on to back the block up into
    // its input, random stalls afterwards per the current pacing mode.
    always @(posedge i_clk) begin : pace_results
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!hold_done && beats_in == HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct(rx_pace));
        end
    end

    // Monitor: compare every accepted result beat with the oldest one owed.
    always @(posedge i_clk) begin : check_results
        bba_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                flag_mismatch("unexpected result", -1, -1);
            end else begin
                want = owed_results.pop_front();
                if (o_block_number !== want.blk || o_status !== want.st)
                    flag_mismatch("result mismatch", want.blk, want.st);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int               live_est;
        int               roll;
        int               alloc_pct;
        logic [1:0]       pace;
        logic [BLK_W-1:0] pick;

        foreach (used_map[w]) used_map[w] = '0;

        // Directed: frees on an empty map, block zero handed out with status ok,
        // reuse of a freed hole, double free, top block number, and an ignored
        // free_block field on allocate. A free past the bitmap cannot be formed
        // here: 15 bits never reach beyond the last word.
        queue_request(bba_pkg::CMD_FREE,  15'd0,      PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'h7FFF,   PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'h7FFF,   PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'd0,      PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'h5555,   PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'd1,      PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'd1,      PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'h2AAA,   PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'd0,      PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'd0,      PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'h5555,   PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'h2AAA,   PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'd63,     PACE_NONE);
        queue_request(bba_pkg::CMD_FREE,  15'd2,      PACE_NONE);
        queue_request(bba_pkg::CMD_ALLOC, 15'd0,      PACE_NONE);
        live_est = 3;

        // Random: mostly allocations and frees of blocks likely in use, so the
        // low words fill and get skipped; some frees hit clear bits, and a
        // share are frees of any block number.
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            pace      = 2'((i / PHASE_BEATS) % 4);
            alloc_pct = (i < PHASE_BEATS) ? 70 : 50;
            roll      = $urandom_range(99);
            if (roll < alloc_pct) begin
                queue_request(bba_pkg::CMD_ALLOC, BLK_W'($urandom_range(32767)), pace);
                live_est++;
            end else if (roll < 88) begin
                pick = BLK_W'($urandom_range(live_est + 7));
                queue_request(bba_pkg::CMD_FREE, pick, pace);
                if (live_est > 0) live_est--;
            end else begin
                queue_request(bba_pkg::CMD_FREE, BLK_W'($urandom_range(32767)), pace);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for every beat to be taken and every result to arrive,
        // then hold off for one full scan to catch stray results.
        while (pending_reqs.size() != 0 || owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d cycles: %0d grants, %0d releases, %0d rejected frees",
                 beats_in, cycle_count, grants, releases, rejects);
        $display("Scans reached word %0d; %0d full reports; %0d mismatches",
                 deepest_word, full_reports, mismatches);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
